>>> rtl/cbp_pkg.sv
// Shared types and constants for the cycle to beam position block.
package cbp_pkg;

  localparam int unsigned PICTURE_CYCLES = 128;
  localparam int unsigned PICTURE_LINES  = 192;

  localparam int unsigned NUM_W      = 32;
  localparam int unsigned DEN_W      = 20;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned STEP_BITS  = 4;
  localparam int unsigned MOD_STAGES = NUM_W / STEP_BITS;
  localparam int unsigned DIV_STAGES = DEN_W / STEP_BITS;
  localparam int unsigned ALL_STAGES = MOD_STAGES + DIV_STAGES;
  localparam int unsigned LATENCY    = ALL_STAGES + 2;

  localparam logic [9:0]  LINE_CYCLES_RST   = 10'd224;
  localparam logic [7:0]  RIGHT_BORDER_RST  = 8'd24;
  localparam logic [7:0]  LEFT_BORDER_RST   = 8'd24;
  localparam logic [19:0] FRAME_CYCLES_RST  = 20'd69888;
  localparam logic [9:0]  FIRST_SHOWN_RST   = 10'd16;
  localparam logic [9:0]  END_SHOWN_RST     = 10'd296;
  localparam logic [9:0]  FIRST_PICTURE_RST = 10'd64;
  localparam logic [9:0]  ORIGIN_X_RST      = 10'd48;

  typedef enum logic [2:0] {
    CFG_LINE_CYCLES   = 3'd0,
    CFG_RIGHT_BORDER  = 3'd1,
    CFG_LEFT_BORDER   = 3'd2,
    CFG_FRAME_CYCLES  = 3'd3,
    CFG_FIRST_SHOWN   = 3'd4,
    CFG_END_SHOWN     = 3'd5,
    CFG_FIRST_PICTURE = 3'd6,
    CFG_ORIGIN_X      = 3'd7
  } cbp_cfg_e;

  typedef enum logic [1:0] {
    REGION_BLANK   = 2'd0,
    REGION_BORDER  = 2'd1,
    REGION_DISPLAY = 2'd2
  } cbp_region_e;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W:0]   rem;
  } cbp_div_t;

endpackage

>>> rtl/cbp_div_stage.sv
// One pipeline stage of restoring division: a few quotient bits per stage.
module cbp_div_stage import cbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  cbp_div_t         data_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             valid_o,
  output cbp_div_t         data_o
);

  cbp_div_t       data_d;
  cbp_div_t       data_q;
  logic           valid_q;
  logic [DEN_W:0] part;
  logic           qbit;

  always_comb begin
    data_d = data_i;
    part   = '0;
    qbit   = 1'b0;
    for (int k = 0; k < STEP_BITS; k++) begin
      part = {data_d.rem[DEN_W-1:0], data_d.num[NUM_W-1]};
      qbit = (part >= {1'b0, divisor_i});
      if (qbit) begin
        part = part - {1'b0, divisor_i};
      end
      data_d.num = {data_d.num[NUM_W-2:0], qbit};
      data_d.rem = part;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/cycle_to_beam_position_top.sv
// Top level: maps a cycle count to the raster beam position and region.
// There are 15 register stages from start to the result strobe.
// Throughput: one beat per clock; busy stays low, the pipeline never stalls.
// Thirteen divider stages do count mod frame length, then line/column split.
// Reset clears the valid bits and loads the register defaults.
module cycle_to_beam_position_top import cbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        cycle_count_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [19:0]        cfg_wdata_i,
  output logic               result_valid_o,
  output logic [1:0]         region_o,
  output logic signed [11:0] pixel_x_o,
  output logic signed [10:0] pixel_y_o,
  output logic signed [7:0]  picture_column_o,
  output logic signed [8:0]  picture_row_o
);

  logic [9:0]  line_cycles_q;
  logic [7:0]  right_border_q;
  logic [7:0]  left_border_q;
  logic [19:0] frame_cycles_q;
  logic [9:0]  first_shown_q;
  logic [9:0]  end_shown_q;
  logic [9:0]  first_picture_q;
  logic [9:0]  origin_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cycles_q   <= LINE_CYCLES_RST;
      right_border_q  <= RIGHT_BORDER_RST;
      left_border_q   <= LEFT_BORDER_RST;
      frame_cycles_q  <= FRAME_CYCLES_RST;
      first_shown_q   <= FIRST_SHOWN_RST;
      end_shown_q     <= END_SHOWN_RST;
      first_picture_q <= FIRST_PICTURE_RST;
      origin_x_q      <= ORIGIN_X_RST;
    end else if (cfg_we_i) begin
      case (cbp_cfg_e'(cfg_idx_i))
        CFG_LINE_CYCLES:   line_cycles_q   <= cfg_wdata_i[9:0];
        CFG_RIGHT_BORDER:  right_border_q  <= cfg_wdata_i[7:0];
        CFG_LEFT_BORDER:   left_border_q   <= cfg_wdata_i[7:0];
        CFG_FRAME_CYCLES:  frame_cycles_q  <= cfg_wdata_i;
        CFG_FIRST_SHOWN:   first_shown_q   <= cfg_wdata_i[9:0];
        CFG_END_SHOWN:     end_shown_q     <= cfg_wdata_i[9:0];
        CFG_FIRST_PICTURE: first_picture_q <= cfg_wdata_i[9:0];
        CFG_ORIGIN_X:      origin_x_q      <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  logic [DEN_W-1:0] frame_eff;
  logic [LEN_W-1:0] len_eff;

  assign frame_eff = (frame_cycles_q == '0) ? DEN_W'(1) : frame_cycles_q;
  assign len_eff   = (line_cycles_q == '0) ? LEN_W'(1) : line_cycles_q;
  assign busy      = 1'b0;

  logic     stg_valid [0:ALL_STAGES];
  cbp_div_t stg_data  [0:ALL_STAGES];
  cbp_div_t stg_in    [0:ALL_STAGES-1];

  assign stg_valid[0] = start & ~busy;
  assign stg_data[0]  = '{num: cycle_count_i, rem: '0};

  for (genvar s = 0; s < ALL_STAGES; s++) begin : g_div
    logic [DEN_W-1:0] divisor;
    if (s == MOD_STAGES) begin : g_split
      assign stg_in[s] = '{num: {stg_data[s].rem[DEN_W-1:0], (NUM_W-DEN_W)'(0)}, rem: '0};
    end else begin : g_pass
      assign stg_in[s] = stg_data[s];
    end
    if (s < MOD_STAGES) begin : g_mod
      assign divisor = frame_eff;
    end else begin : g_line
      assign divisor = DEN_W'(len_eff);
    end
    cbp_div_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (stg_valid[s]),
      .data_i    (stg_in[s]),
      .divisor_i (divisor),
      .valid_o   (stg_valid[s+1]),
      .data_o    (stg_data[s+1])
    );
  end

  logic [DEN_W-1:0]   line;
  logic [LEN_W-1:0]   col;
  logic signed [11:0] left_edge;
  logic signed [11:0] left_diff;
  logic [10:0]        right_stop;
  logic               in_disp;
  logic               in_right;
  logic               in_left;
  logic [11:0]        x_main;

  assign line       = stg_data[ALL_STAGES].num[DEN_W-1:0];
  assign col        = stg_data[ALL_STAGES].rem[LEN_W-1:0];
  assign left_edge  = $signed({2'b00, len_eff}) - $signed({4'b0000, left_border_q});
  assign left_diff  = $signed({2'b00, col}) - left_edge;
  assign right_stop = 11'(PICTURE_CYCLES) + {3'b000, right_border_q};
  assign in_disp    = {1'b0, col} < 11'(PICTURE_CYCLES);
  assign in_right   = {1'b0, col} < right_stop;
  assign in_left    = $signed({2'b00, col}) >= left_edge;
  assign x_main     = {2'b00, origin_x_q} + {1'b0, col, 1'b0};

  logic              a_valid_q;
  logic [LEN_W-1:0]  a_col_q;
  logic [DEN_W:0]    a_target_q;
  logic [11:0]       a_x_q;
  logic              a_painted_q;
  logic              a_disp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= stg_valid[ALL_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    a_col_q     <= col;
    a_disp_q    <= in_disp;
    a_painted_q <= in_disp | in_right | in_left;
    if (in_disp || in_right) begin
      a_target_q <= {1'b0, line};
      a_x_q      <= x_main;
    end else begin
      a_target_q <= {1'b0, line} + (DEN_W+1)'(1);
      a_x_q      <= {left_diff[10:0], 1'b0};
    end
  end

  logic               shown;
  logic               pic;
  logic [10:0]        pic_end;
  logic [10:0]        row;
  logic [10:0]        y_val;
  logic [11:0]        x_sat;
  logic [7:0]         pcol;
  logic [8:0]         prow;
  cbp_region_e        region_d;

  assign pic_end = {1'b0, first_picture_q} + 11'(PICTURE_LINES);
  assign shown   = a_painted_q && (a_target_q >= (DEN_W+1)'(first_shown_q))
                   && (a_target_q < (DEN_W+1)'(end_shown_q));
  assign pic     = a_disp_q && (a_target_q >= (DEN_W+1)'(first_picture_q))
                   && (a_target_q < (DEN_W+1)'(pic_end));
  assign row     = a_target_q[10:0] - {1'b0, first_picture_q};
  assign y_val   = a_target_q[10:0] - {1'b0, first_shown_q};
  assign x_sat   = a_x_q[11] ? 12'd2047 : a_x_q;
  assign pcol    = (a_col_q > LEN_W'(127)) ? 8'd127 : {1'b0, a_col_q[6:0]};
  assign prow    = (row > 11'd255) ? 9'd255 : {1'b0, row[7:0]};

  always_comb begin
    region_d = REGION_BLANK;
    if (shown) begin
      region_d = pic ? REGION_DISPLAY : REGION_BORDER;
    end
  end

  logic              res_valid_q;
  logic [1:0]        region_q;
  logic [11:0]       pixel_x_q;
  logic [10:0]       pixel_y_q;
  logic [7:0]        pcol_q;
  logic [8:0]        prow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    region_q  <= region_d;
    pixel_x_q <= shown ? x_sat : '1;
    pixel_y_q <= shown ? y_val : '1;
    pcol_q    <= (shown && pic) ? pcol : '1;
    prow_q    <= (shown && pic) ? prow : '1;
  end

  assign result_valid_o   = res_valid_q;
  assign region_o         = region_q;
  assign pixel_x_o        = $signed(pixel_x_q);
  assign pixel_y_o        = $signed(pixel_y_q);
  assign picture_column_o = $signed(pcol_q);
  assign picture_row_o    = $signed(prow_q);

`ifndef SYNTHESIS
  a_blank_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (region_o == REGION_BLANK) |->
      (pixel_x_o == -12'sd1) && (pixel_y_o == -11'sd1))
    else $error("blanking beat carries a position");

  a_picture_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (region_o != REGION_DISPLAY) |->
      (picture_column_o == -8'sd1) && (picture_row_o == -9'sd1))
    else $error("picture fields set outside the display region");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(LATENCY) result_valid_o)
    else $error("result beat missing after the pipeline latency");
`endif

endmodule
